>>> rtl/edsp_pkg.sv
package edsp_pkg;

  // Input item kinds carried on the slave tuser bit.
  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_KP_GAIN      = 3'd0,
    REG_KI_GAIN      = 3'd1,
    REG_KD_GAIN      = 3'd2,
    REG_UPDATE_TICKS = 3'd3,
    REG_DIR_INVERT   = 3'd4
  } cfg_reg_e;

  localparam logic [23:0] KpReset       = 24'd688128;
  localparam logic [23:0] KiReset       = 24'd66;
  localparam logic [23:0] KdReset       = 24'd163840;
  localparam logic [7:0]  TicksReset    = 8'd10;

  localparam logic signed [10:0] DriveLimit    = 11'sd999;
  localparam logic signed [31:0] IntegralGate  = 32'sd100;
  localparam logic signed [31:0] IntegralMin   = 32'sh8000_0000;

  typedef struct packed {
    logic [23:0] kp_gain;
    logic [23:0] ki_gain;
    logic [23:0] kd_gain;
    logic [7:0]  update_ticks;
    logic        direction_invert;
  } cfg_t;

  // Gain products and bookkeeping handed from the front stage to the accumulator.
  typedef struct packed {
    logic signed [42:0] kp_term;
    logic signed [56:0] ki_term;
    logic signed [43:0] kd_term;
    logic               updated;
    logic [15:0]        position;
  } prod_t;

endpackage

>>> rtl/encoder_speed_pid_drive_top.sv
// Encoder speed PID drive, one motor channel.
// Slave stream: each transfer is one item. tuser selects the kind: an encoder A rising
// edge (moves the position and window counts by the B level) or a control timer tick.
// Every update_ticks ticks the tick runs an incremental PID step on setpoint minus the
// window count, clears the window and updates the saturated drive.
// Master stream: exactly one result transfer per input transfer, in order, carrying the
// drive, the forward and reverse PWM duties, the position and an updated flag.
// An input transfer passes through an input register, a stage that holds the three
// gain products, and the result register where the Q44.16 sum, rounding and saturation
// land on its way to the output transfer. Throughput is one item per cycle while the
// receiver accepts; the three multipliers sit in the middle stage and the drive
// accumulate closes its loop within the last stage.
// When the receiver stalls, the result register holds and the earlier stages keep
// filling until each holds an item; tready then drops.
// Reset clears all counts, the integral, the error history and the drive, and loads
// the gain and tick registers with their defaults. Configuration writes are registered
// and are meant to be made while the block is idle.
module encoder_speed_pid_drive_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: [0] b_level, [8:1] setpoint, [15:9] zero
  input  logic [15:0] s_axis_tdata,
  // tuser: [0] opcode
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: [10:0] drive_value, [20:11] forward_duty, [30:21] reverse_duty,
  //        [46:31] position_count, [47] zero
  output logic [47:0] m_axis_tdata,
  // tuser: [0] updated
  output logic        m_axis_tuser
);

  edsp_pkg::cfg_t  cfg_q;
  edsp_pkg::prod_t prod;
  logic            prod_valid, prod_ready;

  logic signed [10:0] drive_value;
  logic [9:0]         forward_duty, reverse_duty;
  logic [15:0]        position_count;
  logic               updated;

  // Register file, write only.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp_gain          <= edsp_pkg::KpReset;
      cfg_q.ki_gain          <= edsp_pkg::KiReset;
      cfg_q.kd_gain          <= edsp_pkg::KdReset;
      cfg_q.update_ticks     <= edsp_pkg::TicksReset;
      cfg_q.direction_invert <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        edsp_pkg::REG_KP_GAIN:      cfg_q.kp_gain          <= cfg_data_i;
        edsp_pkg::REG_KI_GAIN:      cfg_q.ki_gain          <= cfg_data_i;
        edsp_pkg::REG_KD_GAIN:      cfg_q.kd_gain          <= cfg_data_i;
        edsp_pkg::REG_UPDATE_TICKS: cfg_q.update_ticks     <= cfg_data_i[7:0];
        edsp_pkg::REG_DIR_INVERT:   cfg_q.direction_invert <= cfg_data_i[0];
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  // Counting, integral bookkeeping and gain multiplies.
  edsp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_opcode_i   (s_axis_tuser),
    .in_b_level_i  (s_axis_tdata[0]),
    .in_setpoint_i ($signed(s_axis_tdata[8:1])),
    .prod_valid_o  (prod_valid),
    .prod_ready_i  (prod_ready),
    .prod_o        (prod)
  );

  // Drive accumulate, saturation and result register.
  edsp_accum u_accum (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .prod_valid_i     (prod_valid),
    .prod_ready_o     (prod_ready),
    .prod_i           (prod),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .drive_value_o    (drive_value),
    .forward_duty_o   (forward_duty),
    .reverse_duty_o   (reverse_duty),
    .position_count_o (position_count),
    .updated_o        (updated)
  );

  assign m_axis_tdata = {1'b0, position_count, reverse_duty, forward_duty, drive_value};
  assign m_axis_tuser = updated;

endmodule

>>> rtl/edsp_front.sv
module edsp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  edsp_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_opcode_i,
  input  logic                in_b_level_i,
  input  logic signed [7:0]   in_setpoint_i,
  output logic                prod_valid_o,
  input  logic                prod_ready_i,
  output edsp_pkg::prod_t     prod_o
);

  logic              in_valid_q;
  logic              opcode_q;
  logic              b_level_q;
  logic signed [7:0] setpoint_q;

  logic [15:0]        position_q, position_d;
  logic [15:0]        window_q;
  logic [7:0]         tick_q, tick_inc;
  logic signed [31:0] integral_q, integral_d;
  logic signed [17:0] prev_err_q;
  logic signed [18:0] delta_q, delta_d;

  logic               prod_valid_q;
  edsp_pkg::prod_t    prod_q, prod_d;

  logic               load_in, load_prod;
  logic               is_edge, is_tick, level, do_update;
  logic signed [17:0] err;
  logic signed [32:0] integral_sum;

  assign load_prod  = in_valid_q && (!prod_valid_q || prod_ready_i);
  assign in_ready_o = !in_valid_q || load_prod;
  assign load_in    = in_valid_i && in_ready_o;

  assign is_edge   = (opcode_q == edsp_pkg::OP_EDGE);
  assign is_tick   = (opcode_q == edsp_pkg::OP_TICK);
  assign level     = b_level_q ^ cfg_i.direction_invert;
  assign tick_inc  = tick_q + 8'd1;
  assign do_update = is_tick && (tick_inc >= cfg_i.update_ticks);

  assign position_d = level ? position_q + 16'd1 : position_q - 16'd1;

  assign err = {{10{setpoint_q[7]}}, setpoint_q} - {{2{window_q[15]}}, window_q};

  always_comb begin
    integral_sum = {integral_q[31], integral_q} + {{15{err[17]}}, err};
    integral_d   = integral_q;
    if (integral_q < edsp_pkg::IntegralGate) begin
      // Only the negative side can overflow here.
      if (integral_sum[32] != integral_sum[31]) begin
        integral_d = edsp_pkg::IntegralMin;
      end else begin
        integral_d = integral_sum[31:0];
      end
    end
    if (err == 18'sd0) begin
      integral_d = 32'sd0;
    end
  end

  assign delta_d = {err[17], err} - {prev_err_q[17], prev_err_q};

  always_comb begin
    prod_d.kp_term  = $signed({1'b0, cfg_i.kp_gain}) * err;
    prod_d.ki_term  = $signed({1'b0, cfg_i.ki_gain}) * integral_q;
    prod_d.kd_term  = $signed({1'b0, cfg_i.kd_gain}) * delta_q;
    prod_d.updated  = do_update;
    prod_d.position = is_edge ? position_d : position_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (load_in) begin
      in_valid_q <= 1'b1;
    end else if (load_prod) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      opcode_q   <= in_opcode_i;
      b_level_q  <= in_b_level_i;
      setpoint_q <= in_setpoint_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q   <= '0;
      window_q     <= '0;
      tick_q       <= '0;
      integral_q   <= '0;
      prev_err_q   <= '0;
      delta_q      <= '0;
      prod_valid_q <= 1'b0;
    end else begin
      if (load_prod) begin
        prod_valid_q <= 1'b1;
      end else if (prod_ready_i) begin
        prod_valid_q <= 1'b0;
      end
      if (load_prod && is_edge) begin
        position_q <= position_d;
        window_q   <= level ? window_q + 16'd1 : window_q - 16'd1;
      end
      if (load_prod && is_tick) begin
        tick_q <= do_update ? 8'd0 : tick_inc;
      end
      if (load_prod && do_update) begin
        window_q   <= '0;
        integral_q <= integral_d;
        delta_q    <= delta_d;
        prev_err_q <= err;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_prod) begin
      prod_q <= prod_d;
    end
  end

  assign prod_valid_o = prod_valid_q;
  assign prod_o       = prod_q;

  a_prod_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prod_valid_q && !prod_ready_i) |=> (prod_valid_q && $stable(prod_q)))
    else $error("product register changed while stalled");

  a_tick_clears_on_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_prod && do_update) |=> (tick_q == 8'd0 && window_q == 16'd0))
    else $error("tick or window count not cleared after update");

  a_integral_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_prod && do_update && integral_q >= edsp_pkg::IntegralGate && err != 18'sd0)
      |=> $stable(integral_q))
    else $error("integral moved while above gate");

endmodule

>>> rtl/edsp_accum.sv
module edsp_accum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               prod_valid_i,
  output logic               prod_ready_o,
  input  edsp_pkg::prod_t    prod_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [10:0] drive_value_o,
  output logic [9:0]         forward_duty_o,
  output logic [9:0]         reverse_duty_o,
  output logic [15:0]        position_count_o,
  output logic               updated_o
);

  logic signed [10:0] drive_q, drive_d;
  logic               out_valid_q;
  logic signed [10:0] drive_out_q;
  logic [9:0]         fwd_q, rev_q;
  logic [15:0]        pos_q;
  logic               upd_q;

  logic               load;
  logic signed [59:0] total;
  logic signed [43:0] whole;
  logic signed [10:0] neg_drive;

  assign prod_ready_o = !out_valid_q || out_ready_i;
  assign load         = prod_valid_i && prod_ready_o;

  // Q44.16 sum; the shifted value is rounded toward zero.
  assign total = {{33{drive_q[10]}}, drive_q, 16'd0}
               + {{17{prod_i.kp_term[42]}}, prod_i.kp_term}
               + {{3{prod_i.ki_term[56]}}, prod_i.ki_term}
               + {{16{prod_i.kd_term[43]}}, prod_i.kd_term};

  assign whole = total[59:16] + {43'd0, (total[59] && (total[15:0] != 16'd0))};

  always_comb begin
    drive_d = drive_q;
    if (prod_i.updated) begin
      if (whole > $signed({{33{1'b0}}, edsp_pkg::DriveLimit})) begin
        drive_d = edsp_pkg::DriveLimit;
      end else if (whole < -$signed({{33{1'b0}}, edsp_pkg::DriveLimit})) begin
        drive_d = -edsp_pkg::DriveLimit;
      end else begin
        drive_d = whole[10:0];
      end
    end
  end

  assign neg_drive = -drive_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        drive_q     <= drive_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      drive_out_q <= drive_d;
      fwd_q       <= drive_d[10] ? 10'd0 : drive_d[9:0];
      rev_q       <= drive_d[10] ? neg_drive[9:0] : 10'd0;
      pos_q       <= prod_i.position;
      upd_q       <= prod_i.updated;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign drive_value_o    = drive_out_q;
  assign forward_duty_o   = fwd_q;
  assign reverse_duty_o   = rev_q;
  assign position_count_o = pos_q;
  assign updated_o        = upd_q;

  a_drive_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drive_q <= edsp_pkg::DriveLimit) && (drive_q >= -edsp_pkg::DriveLimit))
    else $error("drive accumulator out of range");

  a_drive_held_without_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !prod_i.updated) |=> $stable(drive_q))
    else $error("drive changed on an item without update");

  a_duty_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (fwd_q == 10'd0 || rev_q == 10'd0))
    else $error("both duties active");

endmodule
